// File: rtl/core/kmst_pkg.sv
// Shared definitions for the Kruskal spanning-forest weight unit.
// Holds default sizes, the controller states, datapath commands and status.
// No dependencies.
package kmst_pkg;

    localparam int MAX_EDGES_DEF   = 1024;
    localparam int NODE_COUNT_DEF  = 256;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int LABEL_W   = 8;
    localparam int SUM_OUT_W = 24;
    localparam int RANK_W    = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_PASS_INIT,
        ST_PASS_FIRST,
        ST_PASS_RD,
        ST_PASS_CMP,
        ST_PASS_END,
        ST_UF_INIT,
        ST_EDGE_RD,
        ST_EDGE_LD,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_COMP_RD,
        ST_COMP_CHK,
        ST_JOIN,
        ST_JOIN2,
        ST_EMIT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_PASS_INIT,
        OP_PASS_FIRST,
        OP_PASS_RD,
        OP_PASS_CMP,
        OP_PASS_END,
        OP_UF_INIT,
        OP_EDGE_RD,
        OP_EDGE_LD,
        OP_FIND_RD,
        OP_FIND_CHK,
        OP_COMP_RD,
        OP_COMP_CHK,
        OP_JOIN,
        OP_JOIN2,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic empty;
        logic idx_lt;
        logic idx_inc_lt;
        logic swapped;
        logic edges_done;
        logic at_root;
        logic comp_stop;
        logic side;
        logic same_root;
        logic need_j2;
        logic out_busy;
    } status_t;

endpackage

// File: rtl/core/kmst_ctrl.sv
// Controller state machine for the Kruskal spanning-forest weight unit.
// Depends on kmst_pkg for states, commands and status.
module kmst_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               last_edge,
    input  kmst_pkg::status_t  status,
    output logic               in_ready,
    output kmst_pkg::op_t      op
);

    kmst_pkg::state_t state_reg;
    kmst_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kmst_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = kmst_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            kmst_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op = kmst_pkg::OP_LOAD;
                    if (last_edge)
                    begin
                        state_next = kmst_pkg::ST_PASS_INIT;
                    end
                end
            end
            kmst_pkg::ST_PASS_INIT:
            begin
                if (status.empty)
                begin
                    state_next = kmst_pkg::ST_UF_INIT;
                end
                else
                begin
                    op         = kmst_pkg::OP_PASS_INIT;
                    state_next = kmst_pkg::ST_PASS_FIRST;
                end
            end
            kmst_pkg::ST_PASS_FIRST:
            begin
                op         = kmst_pkg::OP_PASS_FIRST;
                state_next = status.idx_lt ? kmst_pkg::ST_PASS_RD : kmst_pkg::ST_PASS_END;
            end
            kmst_pkg::ST_PASS_RD:
            begin
                op         = kmst_pkg::OP_PASS_RD;
                state_next = kmst_pkg::ST_PASS_CMP;
            end
            kmst_pkg::ST_PASS_CMP:
            begin
                op         = kmst_pkg::OP_PASS_CMP;
                state_next = status.idx_inc_lt ? kmst_pkg::ST_PASS_RD : kmst_pkg::ST_PASS_END;
            end
            kmst_pkg::ST_PASS_END:
            begin
                op         = kmst_pkg::OP_PASS_END;
                state_next = status.swapped ? kmst_pkg::ST_PASS_INIT : kmst_pkg::ST_UF_INIT;
            end
            kmst_pkg::ST_UF_INIT:
            begin
                op         = kmst_pkg::OP_UF_INIT;
                state_next = kmst_pkg::ST_EDGE_RD;
            end
            kmst_pkg::ST_EDGE_RD:
            begin
                if (status.edges_done)
                begin
                    state_next = kmst_pkg::ST_EMIT;
                end
                else
                begin
                    op         = kmst_pkg::OP_EDGE_RD;
                    state_next = kmst_pkg::ST_EDGE_LD;
                end
            end
            kmst_pkg::ST_EDGE_LD:
            begin
                op         = kmst_pkg::OP_EDGE_LD;
                state_next = kmst_pkg::ST_FIND_RD;
            end
            kmst_pkg::ST_FIND_RD:
            begin
                op         = kmst_pkg::OP_FIND_RD;
                state_next = kmst_pkg::ST_FIND_CHK;
            end
            kmst_pkg::ST_FIND_CHK:
            begin
                op         = kmst_pkg::OP_FIND_CHK;
                state_next = status.at_root ? kmst_pkg::ST_COMP_RD : kmst_pkg::ST_FIND_RD;
            end
            kmst_pkg::ST_COMP_RD:
            begin
                op         = kmst_pkg::OP_COMP_RD;
                state_next = kmst_pkg::ST_COMP_CHK;
            end
            kmst_pkg::ST_COMP_CHK:
            begin
                op = kmst_pkg::OP_COMP_CHK;
                if (!status.comp_stop)
                begin
                    state_next = kmst_pkg::ST_COMP_RD;
                end
                else if (status.side)
                begin
                    state_next = kmst_pkg::ST_JOIN;
                end
                else
                begin
                    state_next = kmst_pkg::ST_FIND_RD;
                end
            end
            kmst_pkg::ST_JOIN:
            begin
                op = kmst_pkg::OP_JOIN;
                if (!status.same_root && status.need_j2)
                begin
                    state_next = kmst_pkg::ST_JOIN2;
                end
                else
                begin
                    state_next = kmst_pkg::ST_EDGE_RD;
                end
            end
            kmst_pkg::ST_JOIN2:
            begin
                op         = kmst_pkg::OP_JOIN2;
                state_next = kmst_pkg::ST_EDGE_RD;
            end
            kmst_pkg::ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    op         = kmst_pkg::OP_EMIT;
                    state_next = kmst_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = kmst_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// File: rtl/core/kmst_dp.sv
// Datapath of the Kruskal spanning-forest weight unit: edge store, bubble
// sort pass, union-find node table, saturating sum and output register.
// Depends on kmst_pkg; driven by kmst_ctrl commands.
module kmst_dp
#(
    parameter int MAX_EDGES   = kmst_pkg::MAX_EDGES_DEF,
    parameter int NODE_COUNT  = kmst_pkg::NODE_COUNT_DEF,
    parameter int WEIGHT_BITS = kmst_pkg::WEIGHT_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  kmst_pkg::op_t                         op,
    input  logic [kmst_pkg::LABEL_W-1:0]          node_a,
    input  logic [kmst_pkg::LABEL_W-1:0]          node_b,
    input  logic signed [WEIGHT_BITS-1:0]         edge_weight,
    input  logic                                  out_ready,
    output kmst_pkg::status_t                     status,
    output logic                                  out_valid,
    output logic signed [kmst_pkg::SUM_OUT_W-1:0] total_weight,
    output logic                                  edges_dropped
);

    localparam int AW    = $clog2(MAX_EDGES);
    localparam int CW    = AW + 1;
    localparam int NW    = $clog2(NODE_COUNT);
    localparam int EW    = 2 * NW + WEIGHT_BITS;
    localparam int RW    = kmst_pkg::RANK_W;
    localparam int SW    = kmst_pkg::SUM_OUT_W;
    localparam int SUM_W = ((WEIGHT_BITS > SW) ? WEIGHT_BITS : SW) + 1;
    localparam logic [CW-1:0] CAP = CW'(MAX_EDGES);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-8388608);

    // memories
    logic [EW-1:0]    edge_mem [MAX_EDGES];
    logic [RW+NW-1:0] node_mem [NODE_COUNT];
    logic [EW-1:0]    edge_rd_reg;
    logic [RW+NW-1:0] node_rd_reg;
    logic             pv_reg;
    logic [NW-1:0]    paddr_reg;

    logic             e_we;
    logic [AW-1:0]    e_wa;
    logic [EW-1:0]    e_wd;
    logic [AW-1:0]    e_ra;
    logic             n_we;
    logic [NW-1:0]    n_wa;
    logic [RW+NW-1:0] n_wd;
    logic [NW-1:0]    n_ra;

    // control registers
    logic [CW-1:0]         count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  swapped_reg, swapped_next;
    logic [CW-1:0]         ei_reg, ei_next;
    logic                  side_reg, side_next;
    logic signed [SW-1:0]  sum_reg, sum_next;
    logic                  out_valid_reg, out_valid_next;
    logic [NODE_COUNT-1:0] vld_reg, vld_next;

    // payload registers
    logic [EW-1:0]                carry_reg, carry_next;
    logic [NW-1:0]                ea_reg, ea_next;
    logic [NW-1:0]                eb_reg, eb_next;
    logic signed [WEIGHT_BITS-1:0] ew_reg, ew_next;
    logic [NW-1:0]                cur_reg, cur_next;
    logic [NW-1:0]                rootx_reg, rootx_next;
    logic [RW-1:0]                rankx_reg, rankx_next;
    logic [NW-1:0]                roota_reg, roota_next;
    logic [RW-1:0]                ranka_reg, ranka_next;
    logic signed [SW-1:0]         out_sum_reg, out_sum_next;
    logic                         out_drop_reg, out_drop_next;

    logic [NW-1:0]                 la, lb;
    logic signed [WEIGHT_BITS-1:0] rd_w, carry_w;
    logic [NW-1:0]                 rd_a;
    logic [NW-1:0]                 p_node;
    logic [RW-1:0]                 p_rank;
    logic [CW-1:0]                 idx_inc, idx_dec, count_dec;
    logic signed [SUM_W-1:0]       sum_add;
    logic signed [SW-1:0]          sum_sat;

    // fold labels into the node range
    always_comb
    begin
        la = '0;
        lb = '0;
        for (int k = 0; k < 256; k++)
        begin
            if (node_a == 8'(k)) la = NW'(k % NODE_COUNT);
            if (node_b == 8'(k)) lb = NW'(k % NODE_COUNT);
        end
    end

    assign rd_w      = edge_rd_reg[WEIGHT_BITS-1:0];
    assign rd_a      = edge_rd_reg[EW-1:WEIGHT_BITS+NW];
    assign carry_w   = carry_reg[WEIGHT_BITS-1:0];
    assign p_node    = pv_reg ? node_rd_reg[NW-1:0] : paddr_reg;
    assign p_rank    = pv_reg ? node_rd_reg[RW+NW-1:NW] : '0;
    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign sum_add   = SUM_W'(sum_reg) + SUM_W'(ew_reg);

    always_comb
    begin
        if (sum_add > SAT_HI)
        begin
            sum_sat = SAT_HI[SW-1:0];
        end
        else if (sum_add < SAT_LO)
        begin
            sum_sat = SAT_LO[SW-1:0];
        end
        else
        begin
            sum_sat = sum_add[SW-1:0];
        end
    end

    always_comb
    begin
        status.empty      = (count_reg == '0);
        status.idx_lt     = (idx_reg < count_reg);
        status.idx_inc_lt = (idx_inc < count_reg);
        status.swapped    = swapped_reg;
        status.edges_done = (ei_reg == count_reg);
        status.at_root    = (p_node == cur_reg);
        status.comp_stop  = (cur_reg == rootx_reg) || (p_node == rootx_reg);
        status.side       = side_reg;
        status.same_root  = (roota_reg == rootx_reg);
        status.need_j2    = (ranka_reg == rankx_reg) && (rankx_reg != kmst_pkg::RANK_MAX);
        status.out_busy   = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        swapped_next   = swapped_reg;
        ei_next        = ei_reg;
        side_next      = side_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        vld_next       = vld_reg;
        carry_next     = carry_reg;
        ea_next        = ea_reg;
        eb_next        = eb_reg;
        ew_next        = ew_reg;
        cur_next       = cur_reg;
        rootx_next     = rootx_reg;
        rankx_next     = rankx_reg;
        roota_next     = roota_reg;
        ranka_next     = ranka_reg;
        out_sum_next   = out_sum_reg;
        out_drop_next  = out_drop_reg;
        e_we = 1'b0;
        e_wa = '0;
        e_wd = '0;
        e_ra = '0;
        n_we = 1'b0;
        n_wa = '0;
        n_wd = '0;
        n_ra = cur_reg;
        case (op)
            kmst_pkg::OP_LOAD:
            begin
                if (count_reg < CAP)
                begin
                    e_we       = 1'b1;
                    e_wa       = count_reg[AW-1:0];
                    e_wd       = {la, lb, edge_weight};
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            kmst_pkg::OP_PASS_INIT:
            begin
                e_ra         = '0;
                idx_next     = CW'(1);
                swapped_next = 1'b0;
            end
            kmst_pkg::OP_PASS_FIRST:
            begin
                carry_next = edge_rd_reg;
            end
            kmst_pkg::OP_PASS_RD:
            begin
                e_ra = idx_reg[AW-1:0];
            end
            kmst_pkg::OP_PASS_CMP:
            begin
                // carry the heavier edge onward; equal weights keep their order
                e_we = 1'b1;
                e_wa = idx_dec[AW-1:0];
                if (carry_w > rd_w)
                begin
                    e_wd         = edge_rd_reg;
                    swapped_next = 1'b1;
                end
                else
                begin
                    e_wd       = carry_reg;
                    carry_next = edge_rd_reg;
                end
                idx_next = idx_inc;
            end
            kmst_pkg::OP_PASS_END:
            begin
                e_we = 1'b1;
                e_wa = count_dec[AW-1:0];
                e_wd = carry_reg;
            end
            kmst_pkg::OP_UF_INIT:
            begin
                vld_next = '0;
                ei_next  = '0;
            end
            kmst_pkg::OP_EDGE_RD:
            begin
                e_ra = ei_reg[AW-1:0];
            end
            kmst_pkg::OP_EDGE_LD:
            begin
                ea_next   = rd_a;
                eb_next   = edge_rd_reg[WEIGHT_BITS+NW-1:WEIGHT_BITS];
                ew_next   = rd_w;
                cur_next  = rd_a;
                side_next = 1'b0;
            end
            kmst_pkg::OP_FIND_RD,
            kmst_pkg::OP_COMP_RD:
            begin
                n_ra = cur_reg;
            end
            kmst_pkg::OP_FIND_CHK:
            begin
                if (p_node == cur_reg)
                begin
                    rootx_next = cur_reg;
                    rankx_next = p_rank;
                    cur_next   = side_reg ? eb_reg : ea_reg;
                end
                else
                begin
                    cur_next = p_node;
                end
            end
            kmst_pkg::OP_COMP_CHK:
            begin
                if (status.comp_stop)
                begin
                    if (!side_reg)
                    begin
                        roota_next = rootx_reg;
                        ranka_next = rankx_reg;
                        side_next  = 1'b1;
                        cur_next   = eb_reg;
                    end
                end
                else
                begin
                    n_we     = 1'b1;
                    n_wa     = cur_reg;
                    n_wd     = {p_rank, rootx_reg};
                    cur_next = p_node;
                end
            end
            kmst_pkg::OP_JOIN:
            begin
                if (!status.same_root)
                begin
                    sum_next = sum_sat;
                    n_we     = 1'b1;
                    if (ranka_reg > rankx_reg)
                    begin
                        n_wa = rootx_reg;
                        n_wd = {rankx_reg, roota_reg};
                    end
                    else
                    begin
                        n_wa = roota_reg;
                        n_wd = {ranka_reg, rootx_reg};
                    end
                end
                if (status.same_root || !status.need_j2)
                begin
                    ei_next = ei_reg + 1'b1;
                end
            end
            kmst_pkg::OP_JOIN2:
            begin
                n_we    = 1'b1;
                n_wa    = rootx_reg;
                n_wd    = {rankx_reg + 1'b1, rootx_reg};
                ei_next = ei_reg + 1'b1;
            end
            kmst_pkg::OP_EMIT:
            begin
                out_valid_next = 1'b1;
                out_sum_next   = sum_reg;
                out_drop_next  = ovf_reg;
                count_next     = '0;
                ovf_next       = 1'b0;
                sum_next       = '0;
            end
            default:
            begin
                n_ra = cur_reg;
            end
        endcase
        if (n_we)
        begin
            vld_next[n_wa] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            edge_mem[e_wa] <= e_wd;
        end
        edge_rd_reg <= edge_mem[e_ra];
    end

    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            node_mem[n_wa] <= n_wd;
        end
        node_rd_reg <= node_mem[n_ra];
        pv_reg      <= vld_reg[n_ra];
        paddr_reg   <= n_ra;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            swapped_reg   <= 1'b0;
            ei_reg        <= '0;
            side_reg      <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            swapped_reg   <= swapped_next;
            ei_reg        <= ei_next;
            side_reg      <= side_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            vld_reg       <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg    <= carry_next;
        ea_reg       <= ea_next;
        eb_reg       <= eb_next;
        ew_reg       <= ew_next;
        cur_reg      <= cur_next;
        rootx_reg    <= rootx_next;
        rankx_reg    <= rankx_next;
        roota_reg    <= roota_next;
        ranka_reg    <= ranka_next;
        out_sum_reg  <= out_sum_next;
        out_drop_reg <= out_drop_next;
    end

    assign out_valid     = out_valid_reg;
    assign total_weight  = out_sum_reg;
    assign edges_dropped = out_drop_reg;

endmodule

// File: rtl/core/kruskal_mst_weight_unit.sv
// Top level of the Kruskal spanning-forest weight unit.
// Instantiates kmst_ctrl and kmst_dp; depends on kmst_pkg.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, node_a, node_b,          | to block
//          | edge_weight, last_edge                       |
//  out     | out_valid, out_ready, total_weight,          | from block
//          | edges_dropped                                |
//
// Edges load at one transaction per cycle into an edge memory with one write
// port and one read port. After the last edge, bubble passes over it (at most
// n passes, stopping at the first pass with no swap) order the edges by weight;
// then each edge is fetched, both its endpoints are walked to their roots and
// the walked paths compressed through the node table port, and the two sets
// are joined if their roots differ. The result sits in an output register, so
// the next graph loads while it waits; a finished graph holds in the emit step
// until the previous result is taken. Reset clears all control state; node
// validity bits reset the union-find table at the start of every run.
module kruskal_mst_weight_unit
#(
    parameter int MAX_EDGES   = kmst_pkg::MAX_EDGES_DEF,
    parameter int NODE_COUNT  = kmst_pkg::NODE_COUNT_DEF,
    parameter int WEIGHT_BITS = kmst_pkg::WEIGHT_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [kmst_pkg::LABEL_W-1:0]          node_a,
    input  logic [kmst_pkg::LABEL_W-1:0]          node_b,
    input  logic signed [WEIGHT_BITS-1:0]         edge_weight,
    input  logic                                  last_edge,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [kmst_pkg::SUM_OUT_W-1:0] total_weight,
    output logic                                  edges_dropped
);

    kmst_pkg::op_t     dp_op;
    kmst_pkg::status_t dp_status;

    // sequence the load, sort, union-find and emit phases
    kmst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_edge (last_edge),
        .status    (dp_status),
        .in_ready  (in_ready),
        .op        (dp_op)
    );

    // hold the edge store, node table, sum and result register
    kmst_dp
    #(
        .MAX_EDGES   (MAX_EDGES),
        .NODE_COUNT  (NODE_COUNT),
        .WEIGHT_BITS (WEIGHT_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (dp_op),
        .node_a        (node_a),
        .node_b        (node_b),
        .edge_weight   (edge_weight),
        .out_ready     (out_ready),
        .status        (dp_status),
        .out_valid     (out_valid),
        .total_weight  (total_weight),
        .edges_dropped (edges_dropped)
    );

`ifndef SYNTHESIS
    // the last edge of a graph closes the input until the result is formed
    a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_edge) |=> !in_ready)
        else $error("input taken straight after last edge");

    // a result only appears from the emit step
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(dp_op) == kmst_pkg::OP_EMIT))
        else $error("result raised outside emit step");

    // an edge is only stored on an accepted transaction
    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_op == kmst_pkg::OP_LOAD) |-> (in_valid && in_ready))
        else $error("edge load without transaction");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for kruskal_mst_weight_unit: streams weighted edges,
// predicts each graph's spanning-forest weight and compares every result.
// Depends on kmst_pkg and the kruskal_mst_weight_unit RTL.
`timescale 1ns / 100ps

module tb;

    localparam int STORE_DEPTH = kmst_pkg::MAX_EDGES_DEF;
    localparam int NODES       = kmst_pkg::NODE_COUNT_DEF;

    typedef struct {
        logic [kmst_pkg::LABEL_W-1:0] a;
        logic [kmst_pkg::LABEL_W-1:0] b;
        logic signed [15:0]           w;
        logic                         last;
    } edge_item_t;

    typedef struct {
        logic signed [kmst_pkg::SUM_OUT_W-1:0] total;
        logic                                  dropped;
    } forest_result_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                                  in_valid    = 1'b0;
    logic                                  in_ready;
    logic [kmst_pkg::LABEL_W-1:0]          node_a      = '0;
    logic [kmst_pkg::LABEL_W-1:0]          node_b      = '0;
    logic signed [15:0]                    edge_weight = '0;
    logic                                  last_edge   = 1'b0;
    logic                                  out_valid;
    logic                                  out_ready   = 1'b0;
    logic signed [kmst_pkg::SUM_OUT_W-1:0] total_weight;
    logic                                  edges_dropped;

    edge_item_t     edge_queue[$];
    forest_result_t forest_expect[$];

    int  edges_planned  = 0;
    int  edges_accepted = 0;
    int  in_gap         = 0;
    int  out_gap        = 0;
    bit  quiet          = 1'b0;
    bit  failed         = 1'b0;

    // Shadow of the graph currently being loaded
    logic [kmst_pkg::LABEL_W-1:0] graph_a[STORE_DEPTH];
    logic [kmst_pkg::LABEL_W-1:0] graph_b[STORE_DEPTH];
    int                           graph_w[STORE_DEPTH];
    int                           graph_len      = 0;
    bit                           graph_overflow = 1'b0;

    kruskal_mst_weight_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .node_a        (node_a),
        .node_b        (node_b),
        .edge_weight   (edge_weight),
        .last_edge     (last_edge),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .total_weight  (total_weight),
        .edges_dropped (edges_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Find the set root of a node, compressing the walked path onto it.
    function automatic int find_root(ref int parent[NODES], input int n);
        int r;
        int nxt;
        r = n;
        while (parent[r] != r)
            r = parent[r];
        while (parent[n] != r)
        begin
            nxt = parent[n];
            parent[n] = r;
            n = nxt;
        end
        return r;
    endfunction

    // Close the graph: stable sort by weight, join sets, queue the forest weight.
    function automatic void close_graph();
        int             order[$];
        int             parent[NODES];
        int             rank_of[NODES];
        int             key;
        int             j;
        int             ra;
        int             rb;
        longint         sum;
        forest_result_t res;
        for (int i = 0; i < NODES; i++)
        begin
            parent[i]  = i;
            rank_of[i] = 0;
        end
        for (int i = 0; i < graph_len; i++)
            order.insert(order.size(), i);
        // insertion sort keeps arrival order among equal weights
        for (int i = 1; i < graph_len; i++)
        begin
            key = order[i];
            j = i;
            while (j > 0 && graph_w[order[j-1]] > graph_w[key])
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = key;
        end
        sum = 0;
        foreach (order[k])
        begin
            ra = find_root(parent, int'(graph_a[order[k]]));
            rb = find_root(parent, int'(graph_b[order[k]]));
            if (ra != rb)
            begin
                if (rank_of[ra] > rank_of[rb])
                    parent[rb] = ra;
                else
                begin
                    parent[ra] = rb;
                    if (rank_of[ra] == rank_of[rb] && rank_of[rb] < 15)
                        rank_of[rb]++;
                end
                sum += graph_w[order[k]];
                if (sum > 8388607)
                    sum = 8388607;
                if (sum < -8388608)
                    sum = -8388608;
            end
        end
        res.total   = sum[kmst_pkg::SUM_OUT_W-1:0];
        res.dropped = graph_overflow;
        forest_expect.insert(forest_expect.size(), res);
        graph_len      = 0;
        graph_overflow = 1'b0;
    endfunction

    // Take one accepted edge into the shadow graph.
    function automatic void absorb_edge(edge_item_t e);
        if (graph_len < STORE_DEPTH)
        begin
            graph_a[graph_len] = e.a;
            graph_b[graph_len] = e.b;
            graph_w[graph_len] = int'(e.w);
            graph_len++;
        end
        else
            graph_overflow = 1'b1;
        if (e.last)
            close_graph();
    endfunction

    function automatic void plan_edge(int a, int b, int w, bit last);
        edge_item_t e;
        e.a    = a[kmst_pkg::LABEL_W-1:0];
        e.b    = b[kmst_pkg::LABEL_W-1:0];
        e.w    = w[15:0];
        e.last = last;
        edge_queue.insert(edge_queue.size(), e);
        edges_planned++;
    endfunction

    // Plan one random graph; labels sit in a window so that cycles form.
    function automatic void plan_random_graph(int len);
        int span;
        int base;
        int wspan;
        span  = (4 << $urandom_range(0, 6)) - 1;
        base  = $urandom_range(0, 255 - span);
        wspan = ($urandom_range(0, 2) == 0) ? 32767 : $urandom_range(2, 60);
        for (int i = 0; i < len; i++)
            plan_edge(base + $urandom_range(0, span), base + $urandom_range(0, span),
                      $urandom_range(0, 2 * wspan) - wspan, i == len - 1);
    endfunction

    // Driver: present the next pending edge, with bursts of idle cycles.
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || in_ready))
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (edge_queue.size() > 0)
            begin
                edge_item_t e;
                e = edge_queue.pop_front();
                node_a      <= e.a;
                node_b      <= e.b;
                edge_weight <= e.w;
                last_edge   <= e.last;
                in_valid    <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    in_gap <= $urandom_range(1, 5);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver back-pressure, in bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    out_gap <= $urandom_range(1, 5);
            end
        end
    end

    // Monitor: feed accepted edges to the predictor, check each result transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                edge_item_t e;
                e.a    = node_a;
                e.b    = node_b;
                e.w    = edge_weight;
                e.last = last_edge;
                absorb_edge(e);
                edges_accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (forest_expect.size() == 0)
                begin
                    $display("%0t: unexpected result total_weight=%0d edges_dropped=%0b",
                             $time, total_weight, edges_dropped);
                    failed = 1'b1;
                end
                else
                begin
                    forest_result_t exp_res;
                    exp_res = forest_expect.pop_front();
                    if (total_weight !== exp_res.total)
                    begin
                        $display("%0t: total_weight expected %0d actual %0d",
                                 $time, exp_res.total, total_weight);
                        failed = 1'b1;
                    end
                    if (edges_dropped !== exp_res.dropped)
                    begin
                        $display("%0t: edges_dropped expected %0b actual %0b",
                                 $time, exp_res.dropped, edges_dropped);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Hard limit on run time
    initial
    begin
        #20_000_000;
        $display("kruskal_mst_weight_unit regression: fail");
        $finish;
    end

    initial
    begin
        // Directed: lone self loop gives an empty forest
        plan_edge(9, 9, 100, 1'b1);
        // single edge at each weight extreme
        plan_edge(0, 255, 32767, 1'b1);
        plan_edge(255, 0, -32768, 1'b1);
        // triangle with a tie; heaviest edge closes a cycle
        plan_edge(1, 2, 5, 1'b0);
        plan_edge(2, 3, 5, 1'b0);
        plan_edge(3, 1, 5, 1'b0);
        plan_edge(3, 3, -7, 1'b0);
        plan_edge(170, 85, -1, 1'b1);
        // parallel edges, unsorted arrival
        plan_edge(4, 6, 30, 1'b0);
        plan_edge(6, 4, -20, 1'b0);
        plan_edge(4, 6, 0, 1'b0);
        plan_edge(6, 7, 32767, 1'b0);
        plan_edge(7, 4, -32768, 1'b1);
        // Store full: arrive in ascending weight so ordering takes one pass;
        // the edges past capacity, the closing one included, are dropped
        for (int i = 0; i < STORE_DEPTH + 6; i++)
            plan_edge($urandom_range(0, 255), $urandom_range(0, 255), i - 600,
                      i == STORE_DEPTH + 5);
        // next graph after an overflow starts clean
        plan_edge(20, 21, 3, 1'b1);

        // Random graphs, mostly small, a few medium
        while (edges_planned < 1800)
        begin
            if ($urandom_range(0, 15) == 0)
                plan_random_graph($urandom_range(13, 40));
            else
                plan_random_graph($urandom_range(1, 12));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // drop idling for the tail of the stimulus
        wait (edge_queue.size() < 120);
        quiet = 1'b1;
        wait (edges_accepted == edges_planned);
        wait (forest_expect.size() == 0);
        repeat (50) @(posedge clk);
        if (!failed)
            $display("kruskal_mst_weight_unit regression: pass");
        else
            $display("kruskal_mst_weight_unit regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/kmst_pkg.sv
rtl/core/kmst_ctrl.sv
rtl/core/kmst_dp.sv
rtl/core/kruskal_mst_weight_unit.sv
tb/tb.sv
